### hw/rtl/sha256_stream_hasher_macros.svh
// Assertion macros shared by the stream hasher modules.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SSH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SSH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### hw/rtl/ssh_pkg.sv
// Package with the SHA-256 constants, a rotate-right helper and shared types.
`default_nettype none
package ssh_pkg;
   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [7:0] PAD_BYTE = 8'h80;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction
endpackage
`default_nettype wire

### hw/rtl/sha256_stream_hasher.sv
// Top level of the streaming SHA-256 hasher.
// Usage:
//   Requests enter through a queue-style port: drive req_opcode and
//   req_data_byte and raise push while full is low. Opcode zero absorbs one
//   message byte; opcode one finishes the message.
//   Results leave through a second queue-style port: while empty is low the
//   ports rsp_digest_word, rsp_word_index and rsp_last_word show the oldest
//   digest word, and pop takes it. A finish yields eight words, H0 first.
// Timing:
//   A four-entry request queue decouples the front end from the engine, so
//   bytes are taken at one per cycle until it fills. The engine takes one
//   byte per cycle while idle; each 64th byte starts a compression (one load,
//   64 rounds, one feed-forward add), during which the queue holds up to four
//   further bytes. A finish pads one byte per cycle to the end of the block
//   and compresses, once or twice.
// Reset and stall:
//   Reset clears the queue and loads the initial hash values. If the receiver
//   stops popping, the engine holds the digest word and the queue fills,
//   raising full; nothing is dropped.
`default_nettype none
module sha256_stream_hasher
   import ssh_pkg::*;
#(
   parameter int QueueDepth = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         push,
   output logic        full,
   input  wire         req_opcode,
   input  wire  [7:0]  req_data_byte,
   output logic        empty,
   input  wire         pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   req_type in_req, q_req;
   logic q_empty, take, out_valid;

   assign in_req.opcode = req_opcode;
   assign in_req.data_byte = req_data_byte;
   assign empty = !out_valid;

   ssh_fifo #(.Depth(QueueDepth)) u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .push_data(in_req), .full(full),
      .pop(take), .pop_data(q_req), .empty(q_empty));

   ssh_engine u_engine (
      .clock(clock), .reset(reset),
      .req_valid(!q_empty), .req_data(q_req), .req_take(take),
      .out_word(rsp_digest_word), .out_index(rsp_word_index),
      .out_last(rsp_last_word), .out_valid(out_valid), .out_pop(pop));
endmodule
`default_nettype wire

### hw/rtl/ssh_fifo.sv
// Small request queue between the front end and the compression engine.
`default_nettype none
`include "sha256_stream_hasher_macros.svh"
module ssh_fifo
   import ssh_pkg::*;
#(
   parameter int Depth = 4
) (
   input  wire     clock,
   input  wire     reset,
   input  wire     push,
   input  req_type push_data,
   output logic    full,
   input  wire     pop,
   output req_type pop_data,
   output logic    empty
);
   localparam int AW = $clog2(Depth);
   req_type mem_ff [Depth];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = (cnt_ff == (AW+1)'(Depth));
   assign empty = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

   `SSH_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff <= (AW+1)'(Depth))
   `SSH_ASSERT_NEXT(a_full_holds, clock, reset, full && !pop, full)
   `SSH_ASSERT_IMP(a_empty_cnt, clock, reset, empty, wr_ff == rd_ff)
endmodule
`default_nettype wire

### hw/rtl/ssh_engine.sv
// Block buffer, padding sequencer and 64-round compression engine.
`default_nettype none
`include "sha256_stream_hasher_macros.svh"
module ssh_engine
   import ssh_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  req_type     req_data,
   output logic        req_take,
   output logic [31:0] out_word,
   output logic [2:0]  out_index,
   output logic        out_last,
   output logic        out_valid,
   input  wire         out_pop
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD = 3'd1;
   localparam logic [2:0] ST_INIT = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_ADD = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [31:0] blk_ff [16];
   logic [31:0] w_ff [16];
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [5:0] fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0] round_ff;
   logic fin_ff, fin_in;   // message is being finished
   logic lenb_ff, lenb_in; // current pad block carries the length
   logic [2:0] emit_ff;
   logic [5:0] pad_ff;

   logic [31:0] wt, x15, x2, s0, s1, t1, t2, e, a;
   logic [31:0] wbyte;
   logic [3:0] waddr;

   assign req_take = (state_ff == ST_IDLE) && req_valid;
   assign out_valid = (state_ff == ST_EMIT);
   assign out_word = h_ff[emit_ff];
   assign out_index = emit_ff;
   assign out_last = (emit_ff == 3'd7);

   assign x15 = w_ff[4'(round_ff + 6'd1)];
   assign x2 = w_ff[4'(round_ff + 6'd14)];
   assign s0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
   assign s1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
   assign wt = (round_ff < 6'd16) ? blk_ff[round_ff[3:0]]
             : w_ff[round_ff[3:0]] + s0 + w_ff[4'(round_ff + 6'd9)] + s1;
   assign e = v_ff[4];
   assign a = v_ff[0];
   assign t1 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
             + ((e & v_ff[5]) ^ (~e & v_ff[6])) + ROUND_K[round_ff] + wt;
   assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
             + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      bits_in = bits_ff;
      fin_in = fin_ff;
      lenb_in = lenb_ff;
      waddr = fill_ff[5:2];
      wbyte = blk_ff[fill_ff[5:2]];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.opcode == OP_ABSORB) begin
                  wbyte[8*(3-fill_ff[1:0]) +: 8] = req_data.data_byte;
                  bits_in = bits_ff + 64'd8;
                  fill_in = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) state_in = ST_INIT;
               end else begin
                  wbyte[8*(3-fill_ff[1:0]) +: 8] = PAD_BYTE;
                  fin_in = 1'b1;
                  lenb_in = (fill_ff < 6'd56);
                  // A pad byte in the last slot leaves nothing to fill.
                  state_in = (fill_ff == 6'd63) ? ST_INIT : ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // One byte per cycle: zeros, then, in the block that carries the length, the big-endian bit count.
            waddr = pad_ff[5:2];
            wbyte = blk_ff[pad_ff[5:2]];
            if (lenb_ff && pad_ff >= 6'd56)
               wbyte[8*(3-pad_ff[1:0]) +: 8] = bits_ff[8*(63-pad_ff) +: 8];
            else
               wbyte[8*(3-pad_ff[1:0]) +: 8] = 8'h00;
            if (pad_ff == 6'd63) state_in = ST_INIT;
         end
         ST_INIT: state_in = ST_ROUND;
         ST_ROUND: begin
            if (round_ff == 6'd63) state_in = ST_ADD;
         end
         ST_ADD: begin
            fill_in = '0;
            if (!fin_ff) state_in = ST_IDLE;
            else if (lenb_ff) state_in = ST_EMIT;
            else begin
               lenb_in = 1'b1;
               state_in = ST_PAD;
            end
         end
         ST_EMIT: begin
            if (out_pop && emit_ff == 3'd7) begin
               state_in = ST_IDLE;
               fin_in = 1'b0;
               bits_in = '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         bits_ff <= '0;
         fin_ff <= 1'b0;
         lenb_ff <= 1'b0;
         emit_ff <= '0;
         round_ff <= '0;
         pad_ff <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         bits_ff <= bits_in;
         fin_ff <= fin_in;
         lenb_ff <= lenb_in;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  blk_ff[waddr] <= wbyte;
                  pad_ff <= fill_ff + 6'd1;
               end
            end
            ST_PAD: begin
               blk_ff[waddr] <= wbyte;
               pad_ff <= pad_ff + 6'd1;
            end
            ST_INIT: begin
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
               round_ff <= '0;
            end
            ST_ROUND: begin
               w_ff[round_ff[3:0]] <= wt;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               round_ff <= round_ff + 6'd1;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               pad_ff <= '0;
               emit_ff <= '0;
            end
            ST_EMIT: begin
               if (out_pop) begin
                  emit_ff <= emit_ff + 3'd1;
                  if (emit_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   `SSH_ASSERT_IMP(a_take_idle, clock, reset, req_take, state_ff == ST_IDLE)
   `SSH_ASSERT_NEXT(a_round_adv, clock, reset, state_ff == ST_ROUND && round_ff != 6'd63,
      state_ff == ST_ROUND)
   `SSH_ASSERT_IMP(a_emit_fin, clock, reset, out_valid, fin_ff && lenb_ff)
endmodule
`default_nettype wire
